// ----- sv/gpdf_pkg.sv -----
// ----------------------------------------------------------------------------
// gpdf_pkg
// shared constants and types for the gimbal pod telemetry deframer
// ----------------------------------------------------------------------------
package gpdf_pkg;

   localparam logic [7:0] HDR_BYTE = 8'hEE;
   localparam logic [7:0] ID_POD   = 8'h01;
   localparam logic [7:0] ID_MOUNT = 8'h81;
   localparam logic [7:0] MIN_LEN  = 8'd29;

   // payload store covers frame offsets 3..27
   localparam int STORE_BASE  = 3;
   localparam int STORE_DEPTH = 25;
   localparam int STORE_LAST  = STORE_BASE + STORE_DEPTH - 1;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_ID,
      PH_LEN,
      PH_BODY
   } phase_type;

   // first member lands in the top bits, so laser_distance ends up at bit 0
   typedef struct packed {
      logic        [7:0]  pod_mode;
      logic        [15:0] zoom_fraction;
      logic signed [15:0] target_alt;
      logic signed [31:0] target_lon;
      logic signed [31:0] target_lat;
      logic        [7:0]  track_state;
      logic        [7:0]  zoom_level;
      logic signed [15:0] yaw_angle;
      logic signed [15:0] pitch_angle;
      logic signed [15:0] roll_angle;
      logic        [15:0] laser_distance;
   } telem_type;

   typedef struct packed {
      logic      source_kind;
      telem_type telem;
   } record_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } qstat_type;

endpackage

// ----- sv/gpdf_front.sv -----
// ----------------------------------------------------------------------------
// gpdf_front
// frame parser: hunts for the header, checks id, length and checksum,
// keeps the payload bytes and pushes one record per good frame
// ----------------------------------------------------------------------------
module gpdf_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rx_accept,
   input  logic [7:0]           rx_byte,
   output logic                 push,
   output gpdf_pkg::record_type push_rec
);
   import gpdf_pkg::*;

   localparam int IDX_W = $clog2(STORE_DEPTH);

   phase_type  state_ff, state_in;
   logic [7:0] pos_ff, pos_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] sum_ff, sum_in;
   logic       src_ff, src_in;
   logic [7:0] payload_ff [STORE_DEPTH];

   logic             more;
   logic             id_ok;
   logic             wr_en;
   logic [7:0]       wr_off;
   logic [IDX_W-1:0] wr_idx;

   assign more   = ({1'b0, pos_ff} + 9'd1) < {1'b0, len_ff};
   assign id_ok  = (rx_byte == ID_POD) || (rx_byte == ID_MOUNT);
   assign wr_off = pos_ff - 8'(STORE_BASE);
   assign wr_idx = wr_off[IDX_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         PH_HUNT: begin
            if (rx_byte == HDR_BYTE) state_in = PH_ID;
         end
         PH_ID: begin
            if (id_ok) state_in = PH_LEN;
            else if (rx_byte == HDR_BYTE) state_in = PH_ID;
            else state_in = PH_HUNT;
         end
         PH_LEN: begin
            if (rx_byte >= MIN_LEN) state_in = PH_BODY;
            else state_in = PH_HUNT;
         end
         PH_BODY: begin
            if (!more) state_in = PH_HUNT;
         end
         default: state_in = PH_HUNT;
      endcase
   end

   // datapath and outputs
   always_comb begin
      pos_in = pos_ff;
      len_in = len_ff;
      sum_in = sum_ff;
      src_in = src_ff;
      wr_en  = 1'b0;
      push   = 1'b0;
      case (state_ff)
         PH_HUNT: begin
            if (rx_byte == HDR_BYTE) sum_in = HDR_BYTE;
         end
         PH_ID: begin
            if (id_ok) begin
               src_in = (rx_byte == ID_MOUNT);
               sum_in = sum_ff + rx_byte;
            end else if (rx_byte == HDR_BYTE) begin
               sum_in = HDR_BYTE;
            end
         end
         PH_LEN: begin
            if (rx_byte >= MIN_LEN) begin
               len_in = rx_byte;
               sum_in = sum_ff + rx_byte;
               pos_in = 8'(STORE_BASE);
            end
         end
         PH_BODY: begin
            if (more) begin
               wr_en  = rx_accept && (pos_ff >= 8'(STORE_BASE))
                        && (pos_ff <= 8'(STORE_LAST));
               sum_in = sum_ff + rx_byte;
               pos_in = pos_ff + 8'd1;
            end else begin
               // checksum byte closes the frame
               pos_in = 8'd0;
               push   = rx_accept && (rx_byte == sum_ff);
            end
         end
         default: begin
            pos_in = 8'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PH_HUNT;
         pos_ff   <= 8'd0;
         len_ff   <= 8'd0;
         sum_ff   <= 8'd0;
         src_ff   <= 1'b0;
      end else if (rx_accept) begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         sum_ff   <= sum_in;
         src_ff   <= src_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) payload_ff[wr_idx] <= rx_byte;
   end

   // little-endian fields, store index is frame offset minus three
   always_comb begin
      push_rec.source_kind          = src_ff;
      push_rec.telem.laser_distance = {payload_ff[1], payload_ff[0]};
      push_rec.telem.roll_angle     = {payload_ff[3], payload_ff[2]};
      push_rec.telem.pitch_angle    = {payload_ff[5], payload_ff[4]};
      push_rec.telem.yaw_angle      = {payload_ff[7], payload_ff[6]};
      push_rec.telem.zoom_level     = payload_ff[8];
      push_rec.telem.track_state    = payload_ff[9];
      push_rec.telem.target_lat     = {payload_ff[13], payload_ff[12],
                                       payload_ff[11], payload_ff[10]};
      push_rec.telem.target_lon     = {payload_ff[17], payload_ff[16],
                                       payload_ff[15], payload_ff[14]};
      push_rec.telem.target_alt     = {payload_ff[19], payload_ff[18]};
      push_rec.telem.zoom_fraction  = {payload_ff[21], payload_ff[20]};
      push_rec.telem.pod_mode       = payload_ff[24];
   end

endmodule

// ----- sv/gpdf_queue.sv -----
// ----------------------------------------------------------------------------
// gpdf_queue
// short record queue between the parser and the output stage
// ----------------------------------------------------------------------------
module gpdf_queue #(
   parameter int DEPTH = gpdf_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  gpdf_pkg::record_type push_rec,
   input  logic                 pop,
   output gpdf_pkg::record_type head_rec,
   output gpdf_pkg::qstat_type  qstat
);
   import gpdf_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   record_type     entry_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;

   assign wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
   assign rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
   assign count_in  = count_ff + CW'(push) - CW'(pop);

   assign qstat.full      = (count_ff == CW'(DEPTH));
   assign qstat.not_empty = (count_ff != '0);
   assign head_rec        = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_in;
         if (pop) rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_rec;
   end

endmodule

// ----- sv/gpdf_back.sv -----
// ----------------------------------------------------------------------------
// gpdf_back
// output register stage: drains the queue onto the result stream
// ----------------------------------------------------------------------------
module gpdf_back (
   input  logic                 clock,
   input  logic                 reset,
   input  gpdf_pkg::qstat_type  qstat,
   input  gpdf_pkg::record_type head_rec,
   output logic                 pop,
   output logic                 out_valid,
   output gpdf_pkg::record_type out_rec,
   input  logic                 out_ready
);
   import gpdf_pkg::*;

   logic       valid_ff, valid_in;
   record_type rec_ff;

   assign pop       = qstat.not_empty && (!valid_ff || out_ready);
   assign valid_in  = pop || (valid_ff && !out_ready);
   assign out_valid = valid_ff;
   assign out_rec   = rec_ff;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (pop) rec_ff <= head_rec;
   end

endmodule

// ----- sv/gimbal_pod_telemetry_deframer.sv -----
// ----------------------------------------------------------------------------
// gimbal_pod_telemetry_deframer
// byte-stream deframer for gimbal pod telemetry frames
// ----------------------------------------------------------------------------
// Takes one received byte per clock while req_tready is high and emits one
// item per frame whose header, id, length and checksum all pass; bad frames
// are dropped silently. A result item enters the queue when its checksum
// byte is accepted and the output register once the result side is free.
// The parser keeps one byte per cycle going; req_tready drops only while
// the record queue (QUEUE_DEPTH entries) is full behind a stalled output
// register; with frames of at least 29 bytes that takes a long result stall.
module gimbal_pod_telemetry_deframer #(
   parameter int QUEUE_DEPTH = gpdf_pkg::QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] rx_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [15:0] laser_distance, [31:16] roll_angle, [47:32] pitch_angle,
   // [63:48] yaw_angle, [71:64] zoom_level, [79:72] track_state,
   // [111:80] target_lat, [143:112] target_lon, [159:144] target_alt,
   // [175:160] zoom_fraction, [183:176] pod_mode
   output logic [183:0] rsp_tdata,
   output logic         rsp_tuser    // [0] source_kind
);
   import gpdf_pkg::*;

   logic       rx_accept;
   logic       push;
   logic       pop;
   record_type push_rec;
   record_type head_rec;
   record_type out_rec;
   qstat_type  qstat;

   assign req_tready = !qstat.full;
   assign rx_accept  = req_tvalid && req_tready;

   gpdf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .rx_accept (rx_accept),
      .rx_byte   (req_tdata),
      .push      (push),
      .push_rec  (push_rec)
   );

   gpdf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .head_rec (head_rec),
      .qstat    (qstat)
   );

   gpdf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .qstat     (qstat),
      .head_rec  (head_rec),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_rec   (out_rec),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = out_rec.telem;
   assign rsp_tuser = out_rec.source_kind;

endmodule

// ----- sv/gpdf_checker.sv -----
// ----------------------------------------------------------------------------
// gpdf_port_checks
// port-level checks for the telemetry deframer, bound to the top level
// ----------------------------------------------------------------------------
module gpdf_port_checks (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [7:0]   req_tdata,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [183:0] rsp_tdata,
   input logic         rsp_tuser
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result item changed while stalled");

   // nothing comes out right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // input backpressure only when the output side is holding an item
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with idle output");

   // a fresh result follows an accepted checksum byte, through the queue and output register
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result item without a closing byte");

   // accepted bytes are never unknown
   a_req_known: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> !$isunknown(req_tdata))
      else $error("unknown byte accepted");

endmodule

bind gimbal_pod_telemetry_deframer gpdf_port_checks u_checker (.*);
